// ===== sv/ffbt_pkg.sv =====
// Shared types, sizes and codes of the first-fit free block table.
package ffbt_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int ADDR_W     = 32;
    localparam int ID_W       = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_ALLOC  = 2'd1;
    localparam logic [1:0] ACT_MERGE  = 2'd2;
    localparam logic [1:0] ACT_DELETE = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [ID_W-1:0] ident;
        addr_t           base;
        addr_t           length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/ffbt_req_if.sv =====
// Request channel of the free block table.
interface ffbt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] block_id;
    logic [31:0] start_address;
    logic [31:0] block_size;
    logic [31:0] request_size;

    modport source (output valid, action, block_id, start_address, block_size,
                    request_size, input ready);
    modport sink   (input valid, action, block_id, start_address, block_size,
                    request_size, output ready);
endinterface

// ===== sv/ffbt_rsp_if.sv =====
// Result channel of the free block table.
interface ffbt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_id;
    logic [31:0] granted_start;

    modport source (output valid, status, granted_id, granted_start, input ready);
    modport sink   (input valid, status, granted_id, granted_start, output ready);
endinterface

// ===== sv/ffbt_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module ffbt_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/first_fit_free_block_table_top.sv =====
// Top level of the first-fit free block table.
// The table lives in one RAM and every request streams through it once: entries are read
// one per cycle from index 0 up to the fill count and written back compacted or shifted;
// an add to a full table skips the scan and goes straight to the result with the full
// status. The single read port sets the pace of the scan. A new request is taken while
// the previous result still waits in the output register.
module first_fit_free_block_table_top (
    input  logic clk,
    input  logic rst_n,
    ffbt_req_if.sink   req,
    ffbt_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [1:0]                  act_reg;
    logic [ffbt_pkg::ID_W-1:0]   id_reg;
    ffbt_pkg::addr_t             base_reg, len_reg, rq_reg;
    logic [ffbt_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ffbt_pkg::CNT_W-1:0]  rd_reg, rd_next;
    logic [ffbt_pkg::CNT_W-1:0]  k_reg, k_next;
    logic [ffbt_pkg::CNT_W-1:0]  w_reg, w_next;
    logic                        dv_reg, dv_next;
    ffbt_pkg::entry_t            hold_reg, hold_next;
    logic                        hold_v_reg, hold_v_next;
    logic                        found_reg, found_next;
    logic [ffbt_pkg::ID_W-1:0]   gid_reg, gid_next;
    ffbt_pkg::addr_t             gstart_reg, gstart_next;
    logic [1:0]                  status_reg, status_next;

    logic                        out_v_reg;
    logic [1:0]                  out_status_reg;
    logic [15:0]                 out_id_reg;
    logic [31:0]                 out_start_reg;

    logic                        we;
    ffbt_pkg::entry_t            wdata, rdata, new_e;
    logic [ffbt_pkg::IDX_W-1:0]  raddr;
    logic                        accept, load_out;
    logic [ffbt_pkg::ADDR_W:0]   end_sum, len_sum;

    ffbt_ram #(
        .DEPTH(ffbt_pkg::MAX_BLOCKS),
        .WIDTH(ffbt_pkg::ENTRY_W)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(w_reg[ffbt_pkg::IDX_W-1:0]),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign load_out  = (state_reg == S_DONE) && (!out_v_reg || rsp.ready);

    assign new_e.ident  = id_reg;
    assign new_e.base   = base_reg;
    assign new_e.length = len_reg;

    assign end_sum = {1'b0, hold_reg.base} + {1'b0, hold_reg.length};
    assign len_sum = {1'b0, hold_reg.length} + {1'b0, rdata.length};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_next     = rd_reg;
        k_next      = k_reg;
        w_next      = w_reg;
        dv_next     = 1'b0;
        hold_next   = hold_reg;
        hold_v_next = hold_v_reg;
        found_next  = found_reg;
        gid_next    = gid_reg;
        gstart_next = gstart_reg;
        status_next = status_reg;
        we          = 1'b0;
        wdata       = rdata;
        raddr       = rd_reg[ffbt_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_next     = '0;
                    w_next      = '0;
                    hold_v_next = 1'b0;
                    found_next  = 1'b0;
                    gid_next    = '0;
                    gstart_next = '0;
                    status_next = ffbt_pkg::ST_OK;
                    if (req.action == ffbt_pkg::ACT_ADD
                        && count_reg == ffbt_pkg::CNT_W'(ffbt_pkg::MAX_BLOCKS))
                    begin
                        status_next = ffbt_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_reg < count_reg)
                begin
                    dv_next = 1'b1;
                    k_next  = rd_reg;
                    rd_next = rd_reg + 1'b1;
                end

                if (dv_reg)
                begin
                    case (act_reg)
                        ffbt_pkg::ACT_ADD:
                        begin
                            we = 1'b1;
                            if (found_reg)
                            begin
                                wdata     = hold_reg;
                                hold_next = rdata;
                            end
                            else if ((k_reg == '0) ? (base_reg < rdata.base)
                                                   : !(rdata.base < base_reg))
                            begin
                                wdata      = new_e;
                                hold_next  = rdata;
                                found_next = 1'b1;
                            end
                        end
                        ffbt_pkg::ACT_ALLOC:
                        begin
                            if (!found_reg && rdata.length >= rq_reg)
                            begin
                                found_next   = 1'b1;
                                gid_next     = rdata.ident;
                                gstart_next  = rdata.base;
                                wdata.base   = rdata.base + rq_reg;
                                wdata.length = rdata.length - rq_reg;
                                we           = (rdata.length != rq_reg);
                            end
                            else
                            begin
                                we = 1'b1;
                            end
                        end
                        ffbt_pkg::ACT_MERGE:
                        begin
                            hold_v_next = 1'b1;
                            if (!hold_v_reg)
                            begin
                                hold_next = rdata;
                            end
                            else if (end_sum == {1'b0, rdata.base})
                            begin
                                hold_next.length = len_sum[ffbt_pkg::ADDR_W]
                                    ? '1 : len_sum[ffbt_pkg::ADDR_W-1:0];
                            end
                            else
                            begin
                                we        = 1'b1;
                                wdata     = hold_reg;
                                hold_next = rdata;
                            end
                        end
                        default:
                        begin
                            if (!found_reg && rdata.ident == id_reg)
                            begin
                                found_next = 1'b1;
                            end
                            else
                            begin
                                we = 1'b1;
                            end
                        end
                    endcase
                end
                else if (rd_reg == count_reg)
                begin
                    case (act_reg)
                        ffbt_pkg::ACT_ADD:
                        begin
                            we    = 1'b1;
                            wdata = found_reg ? hold_reg : new_e;
                        end
                        ffbt_pkg::ACT_ALLOC:
                        begin
                            status_next = found_reg ? ffbt_pkg::ST_OK
                                                    : ffbt_pkg::ST_ALLOC_FAIL;
                        end
                        ffbt_pkg::ACT_MERGE:
                        begin
                            we    = hold_v_reg;
                            wdata = hold_reg;
                        end
                        default:
                        begin
                            status_next = found_reg ? ffbt_pkg::ST_OK
                                                    : ffbt_pkg::ST_NOT_FOUND;
                        end
                    endcase
                    count_next = we ? w_reg + 1'b1 : w_reg;
                    state_next = S_DONE;
                end

                if (we)
                begin
                    w_next = w_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_reg     <= '0;
            k_reg      <= '0;
            w_reg      <= '0;
            dv_reg     <= 1'b0;
            hold_v_reg <= 1'b0;
            found_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_reg     <= rd_next;
            k_reg      <= k_next;
            w_reg      <= w_next;
            dv_reg     <= dv_next;
            hold_v_reg <= hold_v_next;
            found_reg  <= found_next;
            if (load_out)
            begin
                out_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        gid_reg    <= gid_next;
        gstart_reg <= gstart_next;
        status_reg <= status_next;
        if (accept)
        begin
            act_reg  <= req.action;
            id_reg   <= req.block_id;
            base_reg <= req.start_address[ffbt_pkg::ADDR_W-1:0];
            len_reg  <= req.block_size[ffbt_pkg::ADDR_W-1:0];
            rq_reg   <= req.request_size[ffbt_pkg::ADDR_W-1:0];
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_id_reg     <= gid_reg;
            out_start_reg  <= 32'(gstart_reg);
        end
    end

    assign rsp.valid         = out_v_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.granted_id    = out_id_reg;
    assign rsp.granted_start = out_start_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ffbt_pkg::CNT_W'(ffbt_pkg::MAX_BLOCKS))
        else $error("entry count above table depth");

    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && dv_reg && we) |-> (w_reg <= k_reg))
        else $error("write overtakes unread entry");

    a_add_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && act_reg == ffbt_pkg::ACT_ADD)
        |-> (count_reg < ffbt_pkg::CNT_W'(ffbt_pkg::MAX_BLOCKS)))
        else $error("add scan on full table");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the first-fit free block table: predicts each result and checks it.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] gid;
        logic [31:0] gstart;
    } outcome_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   idle_cycles;
    bit   calm;

    ffbt_req_if req ();
    ffbt_rsp_if rsp ();

    first_fit_free_block_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    logic [15:0] tbl_id  [ffbt_pkg::MAX_BLOCKS];
    logic [31:0] tbl_base[ffbt_pkg::MAX_BLOCKS];
    logic [31:0] tbl_len [ffbt_pkg::MAX_BLOCKS];
    int          tbl_cnt;
    outcome_t    pending_outcomes[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < tbl_cnt; i++)
        begin
            tbl_id[i]   = tbl_id[i+1];
            tbl_base[i] = tbl_base[i+1];
            tbl_len[i]  = tbl_len[i+1];
        end
        if (tbl_cnt > 0)
            tbl_cnt--;
    endfunction

    function automatic outcome_t predict_outcome(logic [1:0] act, logic [15:0] id,
                                                 logic [31:0] base, logic [31:0] len,
                                                 logic [31:0] rq);
        outcome_t o;
        int       pos;
        logic [32:0] sum;
        o = '0;
        case (act)
            ffbt_pkg::ACT_ADD:
            begin
                if (tbl_cnt >= ffbt_pkg::MAX_BLOCKS)
                    o.status = ffbt_pkg::ST_FULL;
                else
                begin
                    if (tbl_cnt == 0 || base < tbl_base[0])
                        pos = 0;
                    else
                    begin
                        pos = 1;
                        while (pos < tbl_cnt && tbl_base[pos] < base)
                            pos++;
                    end
                    for (int i = tbl_cnt; i > pos; i--)
                    begin
                        tbl_id[i]   = tbl_id[i-1];
                        tbl_base[i] = tbl_base[i-1];
                        tbl_len[i]  = tbl_len[i-1];
                    end
                    tbl_id[pos]   = id;
                    tbl_base[pos] = base;
                    tbl_len[pos]  = len;
                    tbl_cnt++;
                    o.status = ffbt_pkg::ST_OK;
                end
            end
            ffbt_pkg::ACT_ALLOC:
            begin
                o.status = ffbt_pkg::ST_ALLOC_FAIL;
                for (int i = 0; i < tbl_cnt; i++)
                begin
                    if (tbl_len[i] >= rq)
                    begin
                        o.status = ffbt_pkg::ST_OK;
                        o.gid    = tbl_id[i];
                        o.gstart = tbl_base[i];
                        tbl_base[i] = tbl_base[i] + rq;
                        tbl_len[i]  = tbl_len[i] - rq;
                        if (tbl_len[i] == 0)
                            drop_entry(i);
                        break;
                    end
                end
            end
            ffbt_pkg::ACT_MERGE:
            begin
                pos = 0;
                while (pos + 1 < tbl_cnt)
                begin
                    if ({1'b0, tbl_base[pos]} + {1'b0, tbl_len[pos]} == {1'b0, tbl_base[pos+1]})
                    begin
                        sum = {1'b0, tbl_len[pos]} + {1'b0, tbl_len[pos+1]};
                        tbl_len[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        drop_entry(pos + 1);
                    end
                    else
                        pos++;
                end
                o.status = ffbt_pkg::ST_OK;
            end
            default:
            begin
                o.status = ffbt_pkg::ST_NOT_FOUND;
                for (int i = 0; i < tbl_cnt; i++)
                begin
                    if (tbl_id[i] == id)
                    begin
                        drop_entry(i);
                        o.status = ffbt_pkg::ST_OK;
                        break;
                    end
                end
            end
        endcase
        return o;
    endfunction

    task automatic send_request(logic [1:0] act, logic [15:0] id, logic [31:0] base,
                                logic [31:0] len, logic [31:0] rq);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.action        <= act;
        req.block_id      <= id;
        req.start_address <= base;
        req.block_size    <= len;
        req.request_size  <= rq;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_outcomes.push_back(predict_outcome(act, id, base, len, rq));
        @(negedge clk);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, rsp.status);
                errors++;
            end
            else
            begin
                outcome_t e;
                e = pending_outcomes.pop_front();
                if (e.status !== rsp.status || e.gid !== rsp.granted_id
                    || e.gstart !== rsp.granted_start)
                begin
                    $display("%0t: mismatch expected %0d/%h/%h actual %0d/%h/%h", $time,
                             e.status, e.gid, e.gstart,
                             rsp.status, rsp.granted_id, rsp.granted_start);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int burst;
        rsp.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                burst--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    burst = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 64));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_request(ffbt_pkg::ACT_ALLOC, 16'h0, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_DELETE, 16'hFFFF, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_MERGE, 16'h0, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_ADD, 16'h0001, 32'h100, 32'h10, 32'h0);
        send_request(ffbt_pkg::ACT_ADD, 16'h0002, 32'h100, 32'h20, 32'h0);
        send_request(ffbt_pkg::ACT_ADD, 16'h0003, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_ALLOC, 16'h0, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_ADD, 16'hFFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0);
        send_request(ffbt_pkg::ACT_ALLOC, 16'h0, 32'h0, 32'h0, 32'h20);
        send_request(ffbt_pkg::ACT_ALLOC, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_request(ffbt_pkg::ACT_ALLOC, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_request(ffbt_pkg::ACT_ADD, 16'h0010, 32'h1000, 32'h8000_0000, 32'h0);
        send_request(ffbt_pkg::ACT_ADD, 16'h0011, 32'h8000_1000, 32'h8000_0000, 32'h0);
        send_request(ffbt_pkg::ACT_ADD, 16'h0012, 32'h2000, 32'h10, 32'h0);
        send_request(ffbt_pkg::ACT_MERGE, 16'h0, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_DELETE, 16'h0012, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_DELETE, 16'h0012, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_ALLOC, 16'h0, 32'h0, 32'h0, 32'h10);
        drain_results();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < ffbt_pkg::MAX_BLOCKS + 3; i++)
            send_request(ffbt_pkg::ACT_ADD, 16'(i), 32'(i * 16), 32'h10, 32'h0);
        send_request(ffbt_pkg::ACT_MERGE, 16'h0, 32'h0, 32'h0, 32'h0);
        send_request(ffbt_pkg::ACT_ALLOC, 16'h0, 32'h0, 32'h0,
                     32'(16 * ffbt_pkg::MAX_BLOCKS));
        drain_results();
    endtask

    task automatic test_random(int n);
        logic [1:0]  act;
        logic [31:0] base;
        logic [31:0] len;
        for (int k = 0; k < n; k++)
        begin
            act = 2'($urandom_range(0, 3));
            if (tbl_cnt < 8 && $urandom_range(0, 1))
                act = ffbt_pkg::ACT_ADD;
            if ($urandom_range(0, 3) == 0)
            begin
                base = 32'($urandom_range(0, 255) * 16);
                len  = 32'($urandom_range(1, 4) * 16);
            end
            else
            begin
                base = rand_word();
                len  = rand_word();
            end
            send_request(act, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)),
                         base, len,
                         $urandom_range(0, 1) ? 32'($urandom_range(0, 48)) : rand_word());
            if (k == n / 2)
                drain_results();
        end
    endtask

    initial
    begin
        errors            = 0;
        calm              = 0;
        rst_n             = 1'b0;
        req.valid         = 1'b0;
        req.action        = ffbt_pkg::ACT_ADD;
        req.block_id      = '0;
        req.start_address = '0;
        req.block_size    = '0;
        req.request_size  = '0;
        tbl_cnt           = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_table();
        test_random(1500);
        calm = 1;
        test_random(300);
        drain_results();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== files.f =====
sv/ffbt_pkg.sv
sv/ffbt_req_if.sv
sv/ffbt_rsp_if.sv
sv/ffbt_ram.sv
sv/first_fit_free_block_table_top.sv
test/tb_top.sv
